// ===== rtl/wmmq_pkg.sv =====
// Shared types, field widths and codes for the wildcard message match queue.
// Used by the controller, the datapath, the top level and the port checker.
package wmmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int RANK_BITS_DEF   = 16;
  localparam int COMM_BITS_DEF   = 8;

  localparam int SRC_W    = 16;
  localparam int TAG_W    = 31;
  localparam int COMM_W   = 8;
  localparam int LEN_W    = 31;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 3;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_INSERT  = 2'd0;
  localparam kind_t KIND_PROBE   = 2'd1;
  localparam kind_t KIND_CONSUME = 2'd2;
  localparam kind_t KIND_RSVD    = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOMATCH = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_BADKIND = 2'd3;

  typedef struct packed {
    logic    req_load;
    logic    insert;
    logic    rd_first;
    logic    rd_next;
    logic    rd_ahead;
    logic    rd_skip;
    logic    shift;
    logic    capture;
    logic    dec_count;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  count_zero;
    logic  full;
    logic  match;
    logic  more;
    logic  shift_more;
  } sts_t;

endpackage

// ===== rtl/wmmq_ctrl.sv =====
// Controller state machine for the wildcard message match queue.
// Drives the datapath through wmmq_pkg::cmd_t and reads wmmq_pkg::sts_t.
module wmmq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  wmmq_pkg::sts_t sts,
  output wmmq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          wmmq_pkg::KIND_INSERT: begin
            cmd.set_status = 1'b1;
            if (sts.full) begin
              cmd.status = wmmq_pkg::ST_FULL;
            end else begin
              cmd.insert = 1'b1;
              cmd.status = wmmq_pkg::ST_OK;
            end
            state_nxt = S_FINISH;
          end
          wmmq_pkg::KIND_RSVD: begin
            cmd.set_status = 1'b1;
            cmd.status     = wmmq_pkg::ST_BADKIND;
            state_nxt      = S_FINISH;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = wmmq_pkg::ST_NOMATCH;
            if (sts.count_zero) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = S_SEARCH;
            end
          end
        endcase
      end
      S_SEARCH: begin
        if (sts.match) begin
          cmd.capture = 1'b1;
          if (sts.kind == wmmq_pkg::KIND_CONSUME) begin
            if (sts.more) begin
              cmd.rd_ahead = 1'b1;
              state_nxt    = S_COMPACT;
            end else begin
              cmd.dec_count = 1'b1;
              state_nxt     = S_FINISH;
            end
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (sts.more) begin
          cmd.rd_next = 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_COMPACT: begin
        cmd.shift = 1'b1;
        if (sts.shift_more) begin
          cmd.rd_skip = 1'b1;
        end else begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/wmmq_dp.sv =====
// Datapath of the wildcard message match queue: descriptor memory, request,
// count and pointer registers, match compare and the result register.
// Depends on wmmq_pkg for widths, codes and the command and status structs.
module wmmq_dp #(
  parameter int QUEUE_DEPTH = wmmq_pkg::QUEUE_DEPTH_DEF,
  parameter int RANK_BITS   = wmmq_pkg::RANK_BITS_DEF,
  parameter int COMM_BITS   = wmmq_pkg::COMM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wmmq_pkg::cmd_t                 cmd,
  output wmmq_pkg::sts_t                 sts,
  input  wmmq_pkg::kind_t                in_kind,
  input  logic [wmmq_pkg::SRC_W-1:0]     in_source_rank,
  input  logic                           in_any_source,
  input  logic [wmmq_pkg::TAG_W-1:0]     in_msg_tag,
  input  logic                           in_any_tag,
  input  logic [wmmq_pkg::COMM_W-1:0]    in_comm_id,
  input  logic [wmmq_pkg::LEN_W-1:0]     in_byte_len,
  output wmmq_pkg::status_t              out_status_code,
  output logic                           out_found,
  output logic [wmmq_pkg::SRC_W-1:0]     out_match_source,
  output logic [wmmq_pkg::TAG_W-1:0]     out_match_tag,
  output logic [wmmq_pkg::LEN_W-1:0]     out_match_size,
  output logic [wmmq_pkg::LEN_W-1:0]     out_copy_len
);

  localparam int SrcW = (RANK_BITS < wmmq_pkg::SRC_W) ? RANK_BITS : wmmq_pkg::SRC_W;
  localparam int CmW  = (COMM_BITS < wmmq_pkg::COMM_W) ? COMM_BITS : wmmq_pkg::COMM_W;
  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SrcW-1:0]              src;
    logic [wmmq_pkg::TAG_W-1:0]   tag;
    logic [CmW-1:0]               comm;
    logic [wmmq_pkg::LEN_W-1:0]   size;
  } entry_t;

  entry_t mem_r [QUEUE_DEPTH];
  entry_t rd_data_r;
  entry_t hit_r;

  wmmq_pkg::kind_t            req_kind_r;
  logic [SrcW-1:0]            req_src_r;
  logic                       req_anys_r;
  logic [wmmq_pkg::TAG_W-1:0] req_tag_r;
  logic                       req_anyt_r;
  logic [CmW-1:0]             req_comm_r;
  logic [wmmq_pkg::LEN_W-1:0] req_len_r;

  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [IdxW-1:0]   ptr_r, ptr_nxt;
  logic [CntW:0]     ptr_p1, ptr_p2;
  logic              found_r;
  wmmq_pkg::status_t status_r;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  entry_t            wr_entry;
  logic [wmmq_pkg::LEN_W-1:0] copy_min;

  assign ptr_p1 = (CntW + 1)'(ptr_r) + (CntW + 1)'(1);
  assign ptr_p2 = (CntW + 1)'(ptr_r) + (CntW + 1)'(2);

  assign sts.kind       = req_kind_r;
  assign sts.count_zero = (cnt_r == '0);
  assign sts.full       = (cnt_r == CntW'(QUEUE_DEPTH));
  assign sts.match      = (rd_data_r.comm == req_comm_r) &&
                          (req_anys_r || (rd_data_r.src == req_src_r)) &&
                          (req_anyt_r || (rd_data_r.tag == req_tag_r));
  assign sts.more       = ptr_p1 < {1'b0, cnt_r};
  assign sts.shift_more = ptr_p2 < {1'b0, cnt_r};

  assign wr_entry.src  = req_src_r;
  assign wr_entry.tag  = req_tag_r;
  assign wr_entry.comm = req_comm_r;
  assign wr_entry.size = req_len_r;

  assign rd_en = cmd.rd_first || cmd.rd_next || cmd.rd_ahead || cmd.rd_skip;

  always_comb begin
    rd_addr = ptr_p1[IdxW-1:0];
    if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.rd_skip) begin
      rd_addr = ptr_p2[IdxW-1:0];
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.rd_first) begin
      ptr_nxt = '0;
    end else if (cmd.rd_next || cmd.shift) begin
      ptr_nxt = ptr_p1[IdxW-1:0];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.insert) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (cmd.dec_count) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  assign copy_min = (req_len_r < hit_r.size) ? req_len_r : hit_r.size;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem_r[cnt_r[IdxW-1:0]] <= wr_entry;
    end else if (cmd.shift) begin
      mem_r[ptr_r] <= rd_data_r;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.req_load) begin
      req_kind_r <= in_kind;
      req_src_r  <= in_source_rank[SrcW-1:0];
      req_anys_r <= in_any_source;
      req_tag_r  <= in_msg_tag;
      req_anyt_r <= in_any_tag;
      req_comm_r <= in_comm_id[CmW-1:0];
      req_len_r  <= in_byte_len;
      found_r    <= 1'b0;
      hit_r      <= '0;
    end else if (cmd.capture) begin
      found_r <= 1'b1;
      hit_r   <= rd_data_r;
    end
    if (cmd.capture) begin
      status_r <= wmmq_pkg::ST_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_code  <= status_r;
      out_found        <= found_r;
      out_match_source <= wmmq_pkg::SRC_W'(hit_r.src);
      out_match_tag    <= hit_r.tag;
      out_match_size   <= hit_r.size;
      out_copy_len     <= (found_r && (req_kind_r == wmmq_pkg::KIND_CONSUME)) ?
                          copy_min : '0;
    end
  end

endmodule

// ===== rtl/wildcard_message_match_queue_unit.sv =====
// Top level of the wildcard message match queue: stream ports, controller
// and datapath. Depends on wmmq_pkg, wmmq_ctrl and wmmq_dp.
//
// The input stream carries one request per transaction: insert a message
// descriptor, probe for the oldest matching descriptor, or consume it.
// The output stream returns exactly one result transaction per request.
// An insert passes through a decode and a finish state before its result
// is registered. A probe or consume walks the descriptor memory one entry
// per cycle from the oldest entry, up to the hit or the end of the queue.
// A consume then closes the gap left by the removed entry, moving one
// entry per cycle. The memory has a single read and a single write port.
// A new request is taken once the previous one has moved into the output
// register, even while that result still waits for the receiver. When the
// receiver stalls, the result holds and the next request waits in its
// final cycle until the output register frees up.
// Reset empties the queue at once; memory contents are not cleared.
module wildcard_message_match_queue_unit #(
  parameter int QUEUE_DEPTH = wmmq_pkg::QUEUE_DEPTH_DEF,
  parameter int RANK_BITS   = wmmq_pkg::RANK_BITS_DEF,
  parameter int COMM_BITS   = wmmq_pkg::COMM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // source_rank[15:0], any_source[16], msg_tag[47:17], any_tag[48],
  // comm_id[56:49], byte_len[87:57]
  input  logic [wmmq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[1:0]
  input  logic [wmmq_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // match_source[15:0], match_tag[46:16], match_size[77:47],
  // copy_len[108:78], zero[111:109]
  output logic [wmmq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status_code[1:0], found[2]
  output logic [wmmq_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  wmmq_pkg::cmd_t             cmd;
  wmmq_pkg::sts_t             sts;
  wmmq_pkg::status_t          res_status;
  logic                       res_found;
  logic [wmmq_pkg::SRC_W-1:0] res_source;
  logic [wmmq_pkg::TAG_W-1:0] res_tag;
  logic [wmmq_pkg::LEN_W-1:0] res_size;
  logic [wmmq_pkg::LEN_W-1:0] res_copy;

  wmmq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wmmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .RANK_BITS   (RANK_BITS),
    .COMM_BITS   (COMM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_tuser[1:0]),
    .in_source_rank   (in_tdata[15:0]),
    .in_any_source    (in_tdata[16]),
    .in_msg_tag       (in_tdata[47:17]),
    .in_any_tag       (in_tdata[48]),
    .in_comm_id       (in_tdata[56:49]),
    .in_byte_len      (in_tdata[87:57]),
    .out_status_code  (res_status),
    .out_found        (res_found),
    .out_match_source (res_source),
    .out_match_tag    (res_tag),
    .out_match_size   (res_size),
    .out_copy_len     (res_copy)
  );

  assign out_tdata = {3'b000, res_copy, res_size, res_tag, res_source};
  assign out_tuser = {res_found, res_status};

endmodule

// ===== rtl/wmmq_checker.sv =====
// Port-level checker for wildcard_message_match_queue_unit, bound to it below.
// Depends on wmmq_pkg for the port widths.
module wmmq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wmmq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [wmmq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result transaction changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A request was accepted while another one was in progress.");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == wmmq_pkg::ST_OK)
    else $error("A matched result carries a failure status.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata == '0)
    else $error("A result without a match carries nonzero fields.");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[108:78] <= out_tdata[77:47])
    else $error("Copy length exceeds the stored message size.");

endmodule

bind wildcard_message_match_queue_unit wmmq_checker u_wmmq_checker (.*);
